// File: hdl/spi_nor_flash_sequencer_unit_macros.svh
// Assertion helpers shared by the sequencer RTL.
`ifndef SPI_NOR_FLASH_SEQUENCER_UNIT_MACROS_SVH
`define SPI_NOR_FLASH_SEQUENCER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SNFS_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
`define SNFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define SNFS_ASSERT(label, clk, rst, ante, cons)
`define SNFS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/snfs_pkg.sv
`default_nettype none
package snfs_pkg;

   localparam int SECTOR_BYTES  = 512;
   localparam int PAGE_BYTES    = 256;
   localparam int PROBE_DUMMIES = 10;

   localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
   localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
   localparam int REMAIN_W     = PAGE_SHIFT + 1;

   localparam int ADDR_W   = 24;
   localparam int SECTOR_W = 15;
   localparam int OFFSET_W = 9;
   localparam int COUNT_W  = 10;
   localparam int CHUNK_W  = 9;
   localparam int LEN_W    = (REMAIN_W > COUNT_W) ? REMAIN_W : COUNT_W;
   localparam int PH_W     = 5;
   localparam int MAX_RES  = 4;
   localparam int NRES_W   = 3;
   localparam int IDX_W    = 2;

   localparam logic [2:0] CMD_PROBE = 3'd0;
   localparam logic [2:0] CMD_READ  = 3'd1;
   localparam logic [2:0] CMD_OPEN  = 3'd2;
   localparam logic [2:0] CMD_CHUNK = 3'd3;
   localparam logic [2:0] CMD_DATA  = 3'd4;
   localparam logic [2:0] CMD_CLOSE = 3'd5;
   localparam logic [2:0] CMD_XDONE = 3'd6;

   localparam logic [2:0] ACT_SEL   = 3'd0;
   localparam logic [2:0] ACT_DESEL = 3'd1;
   localparam logic [2:0] ACT_XFER  = 3'd2;
   localparam logic [2:0] ACT_WAIT  = 3'd3;
   localparam logic [2:0] ACT_REPLY = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_RDY  = 2'd1;
   localparam logic [1:0] ST_NOT_INIT = 2'd2;
   localparam logic [1:0] ST_BUSY     = 2'd3;

   localparam logic [7:0] OP_JEDEC = 8'h9F;
   localparam logic [7:0] OP_READ  = 8'h03;
   localparam logic [7:0] OP_PROG  = 8'h02;
   localparam logic [7:0] OP_ERASE = 8'h20;
   localparam logic [7:0] OP_WREN  = 8'h06;
   localparam logic [7:0] OP_RDSR  = 8'h05;
   localparam logic [7:0] MAKER_ID = 8'hEF;
   localparam logic [7:0] FILL     = 8'hFF;

   typedef struct packed {
      logic [2:0]          cmd;
      logic [SECTOR_W-1:0] sector;
      logic [OFFSET_W-1:0] offset;
      logic [COUNT_W-1:0]  count;
      logic [7:0]          data;
      logic [7:0]          miso;
   } item_type;

   typedef struct packed {
      logic [2:0]         action;
      logic [7:0]         mosi;
      logic [1:0]         status;
      logic [7:0]         read_data;
      logic [CHUNK_W-1:0] chunk_len;
      logic               last;
   } result_type;

   typedef struct packed {
      logic [NRES_W-1:0]         cnt;
      result_type [MAX_RES-1:0]  res;
   } grp_type;

   function automatic result_type mk_res(logic [2:0] act, logic [7:0] mosi, logic [1:0] st,
                                         logic [7:0] rd, logic [CHUNK_W-1:0] clen,
                                         logic last);
      result_type r;
      r.action    = act;
      r.mosi      = mosi;
      r.status    = st;
      r.read_data = rd;
      r.chunk_len = clen;
      r.last      = last;
      return r;
   endfunction

   function automatic result_type xfer_res(logic [7:0] b);
      return mk_res(ACT_XFER, b, ST_OK, 8'd0, '0, 1'b0);
   endfunction

   function automatic result_type bus_res(logic [2:0] act);
      return mk_res(act, 8'd0, ST_OK, 8'd0, '0, 1'b0);
   endfunction

   function automatic result_type reply_res(logic [1:0] st, logic last);
      return mk_res(ACT_REPLY, 8'd0, st, 8'd0, '0, last);
   endfunction

endpackage
`default_nettype wire

// File: hdl/spi_nor_flash_sequencer_unit.sv
// A request beat is taken into the input register; its result group is then loaded into the
// result register and presented on rsp, once the result register is free to take it.
// Throughput: one request per cycle while each yields at most one result beat and rsp_tready
// stays high; a request with k result beats holds the result register for k beats (k up to 4).
// Reset (synchronous, active high): sequencer idle, flash absent, address and
// counters cleared, input and result registers emptied.
`default_nettype none
module spi_nor_flash_sequencer_unit import snfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // sector[14:0], offset[23:15], count[33:24], data[41:34], miso[49:42], zero fill
   input  logic [2:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // mosi[7:0], status[9:8], read_data[17:10], chunk_len[26:18], zero fill
   output logic [2:0]  rsp_tuser,   // action
   output logic        rsp_tlast
);

   item_type   in_ff;
   logic       in_valid_ff;
   logic       fire;
   logic       grp_ready;
   grp_type    grp;
   result_type rsp_res;

   assign fire       = in_valid_ff && grp_ready;
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff.cmd    <= req_tuser;
         in_ff.sector <= req_tdata[14:0];
         in_ff.offset <= req_tdata[23:15];
         in_ff.count  <= req_tdata[33:24];
         in_ff.data   <= req_tdata[41:34];
         in_ff.miso   <= req_tdata[49:42];
      end
   end

   snfs_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (in_ff),
      .grp   (grp)
   );

   snfs_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .grp       (grp),
      .grp_ready (grp_ready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_res   (rsp_res)
   );

   assign rsp_tdata = {5'd0, rsp_res.chunk_len, rsp_res.read_data, rsp_res.status, rsp_res.mosi};
   assign rsp_tuser = rsp_res.action;
   assign rsp_tlast = rsp_res.last;

endmodule
`default_nettype wire

// File: hdl/snfs_core.sv
`default_nettype none
`include "spi_nor_flash_sequencer_unit_macros.svh"
module snfs_core import snfs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     fire,
   input  item_type item,
   output grp_type  grp
);

   localparam logic [4:0] PH_IDLE     = 5'd0;
   localparam logic [4:0] PH_PR_DUMMY = 5'd1;
   localparam logic [4:0] PH_PR_JCMD  = 5'd2;
   localparam logic [4:0] PH_PR_ID0   = 5'd3;
   localparam logic [4:0] PH_PR_ID1   = 5'd4;
   localparam logic [4:0] PH_PR_ID2   = 5'd5;
   localparam logic [4:0] PH_RD_CMD   = 5'd6;
   localparam logic [4:0] PH_RD_A2    = 5'd7;
   localparam logic [4:0] PH_RD_A1    = 5'd8;
   localparam logic [4:0] PH_RD_A0    = 5'd9;
   localparam logic [4:0] PH_RD_DATA  = 5'd10;
   localparam logic [4:0] PH_ER_WREN  = 5'd11;
   localparam logic [4:0] PH_ER_CMD   = 5'd12;
   localparam logic [4:0] PH_ER_A2    = 5'd13;
   localparam logic [4:0] PH_ER_A1    = 5'd14;
   localparam logic [4:0] PH_ER_A0    = 5'd15;
   localparam logic [4:0] PH_PP_WREN  = 5'd16;
   localparam logic [4:0] PH_PP_CMD   = 5'd17;
   localparam logic [4:0] PH_PP_A2    = 5'd18;
   localparam logic [4:0] PH_PP_A1    = 5'd19;
   localparam logic [4:0] PH_PP_A0    = 5'd20;
   localparam logic [4:0] PH_PP_WAIT  = 5'd21;
   localparam logic [4:0] PH_PP_DATA  = 5'd22;
   localparam logic [4:0] PH_ER_PCMD  = 5'd23;
   localparam logic [4:0] PH_ER_POLL  = 5'd24;
   localparam logic [4:0] PH_PP_PCMD  = 5'd25;
   localparam logic [4:0] PH_PP_POLL  = 5'd26;

   logic [PH_W-1:0]     phase_ff, phase_in;
   logic                present_ff, present_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [COUNT_W-1:0]  bytes_left_ff, bytes_left_in;
   logic [SECTOR_W-1:0] open_sector_ff, open_sector_in;
   logic [COUNT_W-1:0]  write_pos_ff, write_pos_in;
   logic [7:0]          maker_ff, maker_in;
   logic [7:0]          type_ff, type_in;

   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic [REMAIN_W-1:0] remain;
   logic [COUNT_W-1:0]  len;
   logic [COUNT_W-1:0]  bytes_dec;
   logic                id_ok;

   assign rd_addr   = (ADDR_W'(item.sector) << SECTOR_SHIFT) + ADDR_W'(item.offset);
   assign wr_addr   = (ADDR_W'(open_sector_ff) << SECTOR_SHIFT) + ADDR_W'(write_pos_ff);
   assign remain    = REMAIN_W'(PAGE_BYTES) - REMAIN_W'(wr_addr[PAGE_SHIFT-1:0]);
   assign len       = (LEN_W'(item.count) > LEN_W'(remain)) ? COUNT_W'(remain) : item.count;
   assign bytes_dec = (bytes_left_ff != '0) ? bytes_left_ff - COUNT_W'(1) : bytes_left_ff;
   assign id_ok     = (maker_ff == MAKER_ID) && (type_ff != 8'd0);

   always_comb begin
      phase_in       = phase_ff;
      present_in     = present_ff;
      addr_in        = addr_ff;
      bytes_left_in  = bytes_left_ff;
      open_sector_in = open_sector_ff;
      write_pos_in   = write_pos_ff;
      maker_in       = maker_ff;
      type_in        = type_ff;
      grp            = '0;
      if (item.cmd <= CMD_CLOSE) begin
         if (item.cmd == CMD_DATA && phase_ff == PH_PP_WAIT) begin
            grp.res[0] = xfer_res(item.data);
            grp.cnt    = NRES_W'(1);
            phase_in   = PH_PP_DATA;
         end else if (phase_ff != PH_IDLE || item.cmd == CMD_DATA) begin
            grp.res[0] = reply_res(ST_BUSY, 1'b1);
            grp.cnt    = NRES_W'(1);
         end else if (item.cmd == CMD_PROBE) begin
            present_in    = 1'b0;
            bytes_left_in = COUNT_W'(PROBE_DUMMIES);
            grp.res[0]    = bus_res(ACT_DESEL);
            grp.res[1]    = xfer_res(FILL);
            grp.cnt       = NRES_W'(2);
            phase_in      = PH_PR_DUMMY;
         end else if (!present_ff) begin
            grp.res[0] = reply_res(ST_NOT_RDY, 1'b1);
            grp.cnt    = NRES_W'(1);
         end else begin
            case (item.cmd)
               CMD_READ: begin
                  addr_in       = rd_addr;
                  bytes_left_in = item.count;
                  grp.res[0]    = bus_res(ACT_SEL);
                  grp.res[1]    = xfer_res(OP_READ);
                  grp.cnt       = NRES_W'(2);
                  phase_in      = PH_RD_CMD;
               end
               CMD_OPEN: begin
                  open_sector_in = item.sector;
                  write_pos_in   = '0;
                  addr_in        = ADDR_W'(item.sector) << SECTOR_SHIFT;
                  grp.res[0]     = bus_res(ACT_SEL);
                  grp.res[1]     = xfer_res(OP_WREN);
                  grp.cnt        = NRES_W'(2);
                  phase_in       = PH_ER_WREN;
               end
               CMD_CHUNK: begin
                  addr_in       = wr_addr;
                  bytes_left_in = len;
                  write_pos_in  = write_pos_ff + len;
                  grp.res[0]    = mk_res(ACT_REPLY, 8'd0, ST_OK, 8'd0, len[CHUNK_W-1:0], 1'b0);
                  grp.res[1]    = bus_res(ACT_SEL);
                  grp.res[2]    = xfer_res(OP_WREN);
                  grp.cnt       = NRES_W'(3);
                  phase_in      = PH_PP_WREN;
               end
               default: begin
                  grp.res[0] = reply_res(ST_OK, 1'b1);
                  grp.cnt    = NRES_W'(1);
               end
            endcase
         end
      end else if (item.cmd == CMD_XDONE) begin
         case (phase_ff)
            PH_PR_DUMMY: begin
               bytes_left_in = bytes_dec;
               if (bytes_dec != '0) begin
                  grp.res[0] = xfer_res(FILL);
                  grp.cnt    = NRES_W'(1);
               end else begin
                  grp.res[0] = bus_res(ACT_SEL);
                  grp.res[1] = xfer_res(OP_JEDEC);
                  grp.cnt    = NRES_W'(2);
                  phase_in   = PH_PR_JCMD;
               end
            end
            PH_PR_JCMD, PH_PR_ID0, PH_PR_ID1: begin
               if (phase_ff == PH_PR_ID0) begin
                  maker_in = item.miso;
               end
               if (phase_ff == PH_PR_ID1) begin
                  type_in = item.miso;
               end
               grp.res[0] = xfer_res(FILL);
               grp.cnt    = NRES_W'(1);
               phase_in   = phase_ff + PH_W'(1);
            end
            PH_PR_ID2: begin
               present_in = id_ok;
               grp.res[0] = bus_res(ACT_DESEL);
               grp.res[1] = reply_res(id_ok ? ST_OK : ST_NOT_INIT, 1'b1);
               grp.cnt    = NRES_W'(2);
               phase_in   = PH_IDLE;
            end
            PH_RD_CMD, PH_ER_CMD, PH_PP_CMD: begin
               grp.res[0] = xfer_res(addr_ff[23:16]);
               grp.cnt    = NRES_W'(1);
               phase_in   = phase_ff + PH_W'(1);
            end
            PH_RD_A2, PH_ER_A2, PH_PP_A2: begin
               grp.res[0] = xfer_res(addr_ff[15:8]);
               grp.cnt    = NRES_W'(1);
               phase_in   = phase_ff + PH_W'(1);
            end
            PH_RD_A1, PH_ER_A1, PH_PP_A1: begin
               grp.res[0] = xfer_res(addr_ff[7:0]);
               grp.cnt    = NRES_W'(1);
               phase_in   = phase_ff + PH_W'(1);
            end
            PH_RD_A0: begin
               if (bytes_left_ff == '0) begin
                  grp.res[0] = bus_res(ACT_DESEL);
                  grp.res[1] = reply_res(ST_OK, 1'b1);
                  grp.cnt    = NRES_W'(2);
                  phase_in   = PH_IDLE;
               end else begin
                  grp.res[0] = xfer_res(FILL);
                  grp.cnt    = NRES_W'(1);
                  phase_in   = PH_RD_DATA;
               end
            end
            PH_RD_DATA: begin
               bytes_left_in = bytes_dec;
               if (bytes_dec == '0) begin
                  grp.res[0] = bus_res(ACT_DESEL);
                  grp.res[1] = mk_res(ACT_REPLY, 8'd0, ST_OK, item.miso, '0, 1'b1);
                  grp.cnt    = NRES_W'(2);
                  phase_in   = PH_IDLE;
               end else begin
                  grp.res[0] = mk_res(ACT_REPLY, 8'd0, ST_OK, item.miso, '0, 1'b0);
                  grp.res[1] = xfer_res(FILL);
                  grp.cnt    = NRES_W'(2);
               end
            end
            PH_ER_WREN, PH_PP_WREN: begin
               grp.res[0] = bus_res(ACT_DESEL);
               grp.res[1] = bus_res(ACT_WAIT);
               grp.res[2] = bus_res(ACT_SEL);
               grp.res[3] = xfer_res((phase_ff == PH_ER_WREN) ? OP_ERASE : OP_PROG);
               grp.cnt    = NRES_W'(4);
               phase_in   = (phase_ff == PH_ER_WREN) ? PH_ER_CMD : PH_PP_CMD;
            end
            PH_ER_A0: begin
               grp.res[0] = bus_res(ACT_DESEL);
               grp.res[1] = bus_res(ACT_SEL);
               grp.res[2] = xfer_res(OP_RDSR);
               grp.cnt    = NRES_W'(3);
               phase_in   = PH_ER_PCMD;
            end
            PH_PP_A0, PH_PP_DATA: begin
               if (phase_ff == PH_PP_DATA) begin
                  bytes_left_in = bytes_dec;
               end
               if (((phase_ff == PH_PP_DATA) ? bytes_dec : bytes_left_ff) != '0) begin
                  phase_in = PH_PP_WAIT;
               end else begin
                  grp.res[0] = bus_res(ACT_DESEL);
                  grp.res[1] = bus_res(ACT_SEL);
                  grp.res[2] = xfer_res(OP_RDSR);
                  grp.cnt    = NRES_W'(3);
                  phase_in   = PH_PP_PCMD;
               end
            end
            PH_ER_PCMD, PH_PP_PCMD: begin
               grp.res[0] = xfer_res(FILL);
               grp.cnt    = NRES_W'(1);
               phase_in   = phase_ff + PH_W'(1);
            end
            PH_ER_POLL, PH_PP_POLL: begin
               if (item.miso[0]) begin
                  grp.res[0] = xfer_res(FILL);
                  grp.cnt    = NRES_W'(1);
               end else begin
                  grp.res[0] = bus_res(ACT_DESEL);
                  grp.res[1] = reply_res(ST_OK, 1'b1);
                  grp.cnt    = NRES_W'(2);
                  phase_in   = PH_IDLE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         present_ff     <= 1'b0;
         addr_ff        <= '0;
         bytes_left_ff  <= '0;
         open_sector_ff <= '0;
         write_pos_ff   <= '0;
         maker_ff       <= '0;
         type_ff        <= '0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         present_ff     <= present_in;
         addr_ff        <= addr_in;
         bytes_left_ff  <= bytes_left_in;
         open_sector_ff <= open_sector_in;
         write_pos_ff   <= write_pos_in;
         maker_ff       <= maker_in;
         type_ff        <= type_in;
      end
   end

   `SNFS_ASSERT(a_wait_has_bytes, clock, reset, phase_ff == PH_PP_WAIT, bytes_left_ff != '0)
   `SNFS_ASSERT(a_probe_absent, clock, reset, phase_ff == PH_PR_DUMMY || phase_ff == PH_PR_JCMD || phase_ff == PH_PR_ID0 || phase_ff == PH_PR_ID1 || phase_ff == PH_PR_ID2, !present_ff)
   `SNFS_ASSERT(a_phase_legal, clock, reset, 1'b1, phase_ff <= PH_PP_POLL)

endmodule
`default_nettype wire

// File: hdl/snfs_outq.sv
`default_nettype none
`include "spi_nor_flash_sequencer_unit_macros.svh"
module snfs_outq import snfs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  grp_type    grp,
   output logic       grp_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_res
);

   grp_type          grp_ff;
   logic             valid_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             beat;
   logic             last_entry;
   logic             load;

   assign beat       = valid_ff && rsp_ready;
   assign last_entry = ({1'b0, idx_ff} == (grp_ff.cnt - NRES_W'(1)));
   assign grp_ready  = !valid_ff || (rsp_ready && last_entry);
   assign load       = fire && (grp.cnt != '0);
   assign rsp_valid  = valid_ff;
   assign rsp_res    = grp_ff.res[idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (beat) begin
         if (last_entry) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff <= grp;
      end
   end

   `SNFS_ASSERT(a_group_nonempty, clock, reset, valid_ff, grp_ff.cnt != '0)
   `SNFS_ASSERT(a_idx_in_group, clock, reset, valid_ff, {1'b0, idx_ff} < grp_ff.cnt)
   `SNFS_ASSERT_NEXT(a_group_advance, clock, reset, beat && !last_entry, valid_ff && idx_ff == $past(idx_ff) + IDX_W'(1))

endmodule
`default_nettype wire

// File: dv/spi_nor_flash_sequencer_unit_monitor.sv
`timescale 1ns / 100ps
module spi_nor_flash_sequencer_unit_monitor import snfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,   // sector[14:0], offset[23:15], count[33:24], data[41:34], miso[49:42]
   input  logic [2:0]  req_tuser,   // cmd
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // mosi[7:0], status[9:8], read_data[17:10], chunk_len[26:18]
   input  logic [2:0]  rsp_tuser,   // action
   input  logic        rsp_tlast,
   output int          mismatches,
   output int          outstanding
);

   localparam logic [7:0] STATUS_BUSY  = 8'h01;
   localparam int         REPORT_LIMIT = 10;

   typedef enum logic [4:0] {
      S_IDLE, S_PR_DUMMY, S_PR_JCMD, S_PR_ID0, S_PR_ID1, S_PR_ID2,
      S_RD_CMD, S_RD_A2, S_RD_A1, S_RD_A0, S_RD_DATA,
      S_ER_WREN, S_ER_CMD, S_ER_A2, S_ER_A1, S_ER_A0,
      S_PP_WREN, S_PP_CMD, S_PP_A2, S_PP_A1, S_PP_A0, S_PP_WAIT, S_PP_DATA,
      S_ER_PCMD, S_ER_POLL, S_PP_PCMD, S_PP_POLL
   } seq_state_type;

   seq_state_type state;
   logic          present;
   logic [23:0]   addr;
   logic [9:0]    left;
   logic [14:0]   open_sec;
   logic [9:0]    wr_pos;
   logic [7:0]    maker;
   logic [7:0]    dev_type;
   result_type    pending_actions[$];

   task automatic queue_action(input logic [2:0] act, input logic [7:0] mosi,
                               input logic [1:0] st, input logic [7:0] rd,
                               input logic [8:0] clen, input logic lst);
      result_type r;
      r.action    = act;
      r.mosi      = mosi;
      r.status    = st;
      r.read_data = rd;
      r.chunk_len = clen;
      r.last      = lst;
      pending_actions.push_back(r);
   endtask

   task automatic queue_xfer(input logic [7:0] b);
      queue_action(ACT_XFER, b, ST_OK, 8'd0, 9'd0, 1'b0);
   endtask

   task automatic queue_bus(input logic [2:0] act);
      queue_action(act, 8'd0, ST_OK, 8'd0, 9'd0, 1'b0);
   endtask

   task automatic queue_reply(input logic [1:0] st);
      queue_action(ACT_REPLY, 8'd0, st, 8'd0, 9'd0, 1'b1);
   endtask

   task automatic advance_sequencer(input logic [2:0] cmd, input logic [14:0] sector,
                                    input logic [8:0] offset, input logic [9:0] count,
                                    input logic [7:0] data, input logic [7:0] miso);
      int remain;
      int len;
      if (cmd <= CMD_CLOSE) begin
         if (cmd == CMD_DATA && state == S_PP_WAIT) begin
            queue_xfer(data);
            state = S_PP_DATA;
         end else if (state != S_IDLE || cmd == CMD_DATA) begin
            queue_reply(ST_BUSY);
         end else if (cmd == CMD_PROBE) begin
            present = 1'b0;
            left    = 10'(PROBE_DUMMIES);
            queue_bus(ACT_DESEL);
            queue_xfer(FILL);
            state = S_PR_DUMMY;
         end else if (!present) begin
            queue_reply(ST_NOT_RDY);
         end else begin
            case (cmd)
               CMD_READ: begin
                  addr = 24'(int'(sector) * SECTOR_BYTES + int'(offset));
                  left = count;
                  queue_bus(ACT_SEL);
                  queue_xfer(OP_READ);
                  state = S_RD_CMD;
               end
               CMD_OPEN: begin
                  open_sec = sector;
                  wr_pos   = 10'd0;
                  addr     = 24'(int'(sector) * SECTOR_BYTES);
                  queue_bus(ACT_SEL);
                  queue_xfer(OP_WREN);
                  state = S_ER_WREN;
               end
               CMD_CHUNK: begin
                  addr   = 24'(int'(open_sec) * SECTOR_BYTES + int'(wr_pos));
                  remain = PAGE_BYTES - int'(addr) % PAGE_BYTES;
                  len    = (int'(count) > remain) ? remain : int'(count);
                  left   = 10'(len);
                  wr_pos = 10'(int'(wr_pos) + len);
                  queue_action(ACT_REPLY, 8'd0, ST_OK, 8'd0, 9'(len), 1'b0);
                  queue_bus(ACT_SEL);
                  queue_xfer(OP_WREN);
                  state = S_PP_WREN;
               end
               default: queue_reply(ST_OK);
            endcase
         end
      end else if (cmd == CMD_XDONE) begin
         case (state)
            S_PR_DUMMY: begin
               if (left > 0) left--;
               if (left > 0) begin
                  queue_xfer(FILL);
               end else begin
                  queue_bus(ACT_SEL);
                  queue_xfer(OP_JEDEC);
                  state = S_PR_JCMD;
               end
            end
            S_PR_JCMD: begin
               queue_xfer(FILL);
               state = S_PR_ID0;
            end
            S_PR_ID0: begin
               maker = miso;
               queue_xfer(FILL);
               state = S_PR_ID1;
            end
            S_PR_ID1: begin
               dev_type = miso;
               queue_xfer(FILL);
               state = S_PR_ID2;
            end
            S_PR_ID2: begin
               present = (maker == MAKER_ID) && (dev_type != 8'd0);
               queue_bus(ACT_DESEL);
               queue_reply(present ? ST_OK : ST_NOT_INIT);
               state = S_IDLE;
            end
            S_RD_CMD, S_ER_CMD, S_PP_CMD: begin
               queue_xfer(addr[23:16]);
               state = seq_state_type'(state + 1);
            end
            S_RD_A2, S_ER_A2, S_PP_A2: begin
               queue_xfer(addr[15:8]);
               state = seq_state_type'(state + 1);
            end
            S_RD_A1, S_ER_A1, S_PP_A1: begin
               queue_xfer(addr[7:0]);
               state = seq_state_type'(state + 1);
            end
            S_RD_A0: begin
               if (left == 0) begin
                  queue_bus(ACT_DESEL);
                  queue_reply(ST_OK);
                  state = S_IDLE;
               end else begin
                  queue_xfer(FILL);
                  state = S_RD_DATA;
               end
            end
            S_RD_DATA: begin
               if (left > 0) left--;
               if (left == 0) begin
                  queue_bus(ACT_DESEL);
                  queue_action(ACT_REPLY, 8'd0, ST_OK, miso, 9'd0, 1'b1);
                  state = S_IDLE;
               end else begin
                  queue_action(ACT_REPLY, 8'd0, ST_OK, miso, 9'd0, 1'b0);
                  queue_xfer(FILL);
               end
            end
            S_ER_WREN, S_PP_WREN: begin
               queue_bus(ACT_DESEL);
               queue_bus(ACT_WAIT);
               queue_bus(ACT_SEL);
               queue_xfer(state == S_ER_WREN ? OP_ERASE : OP_PROG);
               state = (state == S_ER_WREN) ? S_ER_CMD : S_PP_CMD;
            end
            S_ER_A0: begin
               queue_bus(ACT_DESEL);
               queue_bus(ACT_SEL);
               queue_xfer(OP_RDSR);
               state = S_ER_PCMD;
            end
            S_PP_A0, S_PP_DATA: begin
               if (state == S_PP_DATA && left > 0) left--;
               if (left > 0) begin
                  state = S_PP_WAIT;
               end else begin
                  queue_bus(ACT_DESEL);
                  queue_bus(ACT_SEL);
                  queue_xfer(OP_RDSR);
                  state = S_PP_PCMD;
               end
            end
            S_ER_PCMD, S_PP_PCMD: begin
               queue_xfer(FILL);
               state = seq_state_type'(state + 1);
            end
            S_ER_POLL, S_PP_POLL: begin
               if ((miso & STATUS_BUSY) != 8'd0) begin
                  queue_xfer(FILL);
               end else begin
                  queue_bus(ACT_DESEL);
                  queue_reply(ST_OK);
                  state = S_IDLE;
               end
            end
            default: ;
         endcase
      end
   endtask

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (reset) begin
         state    = S_IDLE;
         present  = 1'b0;
         addr     = 24'd0;
         left     = 10'd0;
         open_sec = 15'd0;
         wr_pos   = 10'd0;
         maker    = 8'd0;
         dev_type = 8'd0;
         pending_actions.delete();
         mismatches = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.action    = rsp_tuser;
            seen.mosi      = rsp_tdata[7:0];
            seen.status    = rsp_tdata[9:8];
            seen.read_data = rsp_tdata[17:10];
            seen.chunk_len = rsp_tdata[26:18];
            seen.last      = rsp_tlast;
            if (pending_actions.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected rsp beat act=%0d mosi=%h status=%0d rdata=%h clen=%0d last=%b",
                           $time, seen.action, seen.mosi, seen.status, seen.read_data,
                           seen.chunk_len, seen.last);
            end else begin
               want = pending_actions.pop_front();
               if (seen.action !== want.action || seen.mosi !== want.mosi ||
                   seen.status !== want.status || seen.read_data !== want.read_data ||
                   seen.chunk_len !== want.chunk_len || seen.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: rsp beat mismatch, expected act=%0d mosi=%h status=%0d rdata=%h clen=%0d last=%b",
                              $time, want.action, want.mosi, want.status, want.read_data,
                              want.chunk_len, want.last);
                     $display("   got act=%0d mosi=%h status=%0d rdata=%h clen=%0d last=%b",
                              seen.action, seen.mosi, seen.status, seen.read_data,
                              seen.chunk_len, seen.last);
                  end
               end
            end
         end
         if (req_tvalid && req_tready)
            advance_sequencer(req_tuser, req_tdata[14:0], req_tdata[23:15], req_tdata[33:24],
                              req_tdata[41:34], req_tdata[49:42]);
      end
      outstanding = pending_actions.size();
   end

endmodule

// File: dv/spi_nor_flash_sequencer_unit_test.sv
`timescale 1ns / 100ps
module spi_nor_flash_sequencer_unit_test import snfs_pkg::*;;

   localparam int         QUIET_LIMIT  = 2000;
   localparam int         LONG_HOLD    = 400;
   localparam int         RANDOM_ITEMS = 160;
   localparam int         STAGE_ITEMS  = 40;
   localparam logic [2:0] CMD_UNUSED   = 3'd7;
   localparam logic [7:0] STATUS_BUSY  = 8'h01;

   typedef enum int {FREE_RUN, SEND_SPARSE, RECV_STALL, BOTH_SLOW} pace_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   int          mismatches;
   int          outstanding;

   pace_type pace          = FREE_RUN;
   int       hold_requests = 0;
   int       holds_served  = 0;
   int       hold_left     = 0;
   int       quiet         = 0;
   int       sent          = 0;
   int       wr_pos        = 0;
   bit       present       = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   spi_nor_flash_sequencer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   spi_nor_flash_sequencer_unit_monitor u_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   function automatic bit roll(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic bit sender_gap();
      return roll(pace == SEND_SPARSE ? 76 : (pace == BOTH_SLOW ? 16 : 0));
   endfunction

   // hold off for a long stretch on request, else stall by pace
   always @(negedge clock) begin
      if (hold_left == 0 && holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !roll(pace == RECV_STALL ? 76 : (pace == BOTH_SLOW ? 16 : 0));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet = 0;
      else
         quiet++;
      if (quiet >= QUIET_LIMIT) begin
         $display("spi_nor_flash_sequencer_unit_test: done, errors");
         $finish;
      end
   end

   task automatic offer(input logic [2:0] cmd, input logic [14:0] sector,
                        input logic [8:0] offset, input logic [9:0] count,
                        input logic [7:0] data, input logic [7:0] miso);
      if (sender_gap()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
         while (sender_gap()) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'd0, miso, data, count, offset, sector};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic offer_any(input logic [2:0] cmd);
      offer(cmd, 15'($urandom), 9'($urandom), 10'($urandom_range(0, 512)),
            8'($urandom), 8'($urandom));
   endtask

   task automatic maybe_reject(input bit allow_data);
      logic [2:0] cmd;
      if (!roll(8)) return;
      do cmd = 3'($urandom_range(0, 7));
      while (cmd == CMD_XDONE || (cmd == CMD_DATA && !allow_data));
      offer_any(cmd);
   endtask

   task automatic xfer_done(input logic [7:0] miso);
      maybe_reject(1'b1);
      offer(CMD_XDONE, 15'($urandom), 9'($urandom), 10'($urandom_range(0, 512)),
            8'($urandom), miso);
   endtask

   task automatic busy_poll();
      int spins;
      spins = $urandom_range(0, 3);
      xfer_done(8'($urandom));
      repeat (spins) xfer_done(8'($urandom) | STATUS_BUSY);
      xfer_done(8'($urandom) & ~STATUS_BUSY);
   endtask

   task automatic probe_flash(input bit good);
      logic [7:0] maker;
      logic [7:0] dev;
      maker = MAKER_ID;
      dev   = 8'($urandom_range(1, 255));
      if (!good) begin
         if (roll(50)) dev = 8'd0;
         else do maker = 8'($urandom); while (maker == MAKER_ID);
      end
      offer_any(CMD_PROBE);
      repeat (PROBE_DUMMIES + 1) xfer_done(8'($urandom));
      xfer_done(maker);
      xfer_done(dev);
      xfer_done(8'($urandom));
      present = good;
   endtask

   task automatic read_sector(input logic [14:0] sector, input logic [8:0] offset,
                              input logic [9:0] count);
      offer(CMD_READ, sector, offset, count, 8'($urandom), 8'($urandom));
      if (present) repeat (4 + count) xfer_done(8'($urandom));
   endtask

   task automatic open_write(input logic [14:0] sector);
      offer(CMD_OPEN, sector, 9'($urandom), 10'($urandom_range(0, 512)),
            8'($urandom), 8'($urandom));
      if (present) begin
         wr_pos = 0;
         repeat (5) xfer_done(8'($urandom));
         busy_poll();
      end
   endtask

   task automatic write_chunk(input logic [9:0] count);
      int len;
      len = PAGE_BYTES - wr_pos % PAGE_BYTES;
      if (count < len) len = count;
      offer(CMD_CHUNK, 15'($urandom), 9'($urandom), count, 8'($urandom), 8'($urandom));
      if (present) begin
         wr_pos = (wr_pos + len) % (1 << COUNT_W);
         repeat (5) xfer_done(8'($urandom));
         repeat (len) begin
            maybe_reject(1'b0);
            offer(CMD_DATA, 15'($urandom), 9'($urandom), 10'($urandom_range(0, 512)),
                  8'($urandom), 8'($urandom));
            xfer_done(8'($urandom));
         end
         busy_poll();
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      int start;
      int stage;
      int pick;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      offer_any(CMD_UNUSED);
      offer_any(CMD_XDONE);
      offer_any(CMD_DATA);
      read_sector(15'h7FFF, 9'h1FF, 10'd512);
      open_write(15'd0);
      write_chunk(10'd512);
      offer_any(CMD_CLOSE);
      probe_flash(1'b1);
      read_sector(15'h7FFF, 9'h1FF, 10'd0);

      start = sent;
      stage = 0;
      while (sent - start < RANDOM_ITEMS) begin
         if ((sent - start) / STAGE_ITEMS != stage) begin
            stage = (sent - start) / STAGE_ITEMS;
            drain();
            pace = pace_type'(stage % 4);
            if (pace == RECV_STALL) hold_requests++;
         end
         pick = $urandom_range(0, 99);
         if (!present && pick >= 10 && roll(60))
            probe_flash(1'b1);
         else if (pick < 10)
            probe_flash(roll(75));
         else if (pick < 32)
            read_sector(15'($urandom), 9'($urandom),
                        roll(20) ? 10'd0 : (roll(88) ? 10'($urandom_range(1, 5))
                                                     : 10'($urandom_range(6, 40))));
         else if (pick < 45)
            open_write(roll(20) ? (roll(50) ? 15'd0 : 15'h7FFF) : 15'($urandom));
         else if (pick < 75)
            write_chunk(roll(15) ? 10'd0 : (roll(92) ? 10'($urandom_range(1, 6))
                                                     : 10'($urandom_range(7, 24))));
         else if (pick < 82)
            offer_any(CMD_CLOSE);
         else begin
            case ($urandom_range(0, 2))
               0:       offer_any(CMD_UNUSED);
               1:       offer_any(CMD_XDONE);
               default: offer_any(CMD_DATA);
            endcase
         end
      end

      drain();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("spi_nor_flash_sequencer_unit_test: done, clean");
      else
         $display("spi_nor_flash_sequencer_unit_test: done, errors");
      $finish;
   end

endmodule
